@@ hw/rtl/bbr_pkg.sv @@
// Box blur package: payload structs, window and tag types, register indexes.
// Shared by bbr_window, bbr_out and the top unit; depends on nothing.
package bbr_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned CoordW   = 11;
  localparam int unsigned SumW     = 12;

  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam logic [CfgDataW-1:0] IMAGE_WIDTH_RESET  = 12'd640;
  localparam logic [CfgDataW-1:0] IMAGE_HEIGHT_RESET = 12'd480;

  // floor(x / 9) == (x * 7282) >> 16 for every x below 2296
  localparam logic [12:0] DIV9_MUL  = 13'd7282;
  localparam int unsigned Div9Shift = 16;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0]        red_out;
    logic [7:0]        green_out;
    logic [7:0]        blue_out;
    logic [7:0]        alpha_out;
    logic [CoordW-1:0] out_col;
    logic [CoordW-1:0] out_row;
    logic              run_last;
    logic              frame_done;
  } pix_out_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  typedef struct packed {
    logic [SumW-1:0] red;
    logic [SumW-1:0] green;
    logic [SumW-1:0] blue;
  } sums_t;

  typedef struct packed {
    logic              blur;
    logic              pass;
    logic              frame_end;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
  } tag_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BLUR,
    ST_PASS
  } out_state_e;

endpackage

@@ hw/rtl/bbr_line_mem.sv @@
// Line store: one-write, one-read synchronous RAM, registered read data.
// Stand-alone; no package needed.
module bbr_line_mem #(
  parameter int unsigned Depth = 2048,
  parameter int unsigned Width = 32,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/bbr_window.sv @@
// Window stage: six window registers, 3x3 channel sums, sum register.
// Depends on bbr_pkg.
module bbr_window (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          restart_i,
  input  logic          adv_i,
  input  logic          b_valid_i,
  input  bbr_pkg::rgba_t b_px_i,
  input  bbr_pkg::rgba_t b_above2_i,
  input  bbr_pkg::rgba_t b_above1_i,
  input  bbr_pkg::tag_t  b_tag_i,
  output logic          c_valid_o,
  output bbr_pkg::sums_t c_sums_o,
  output bbr_pkg::rgba_t c_px_o,
  output bbr_pkg::tag_t  c_tag_o
);
  import bbr_pkg::*;

  rgba_t win_q [6];
  rgba_t win_d [6];
  rgba_t taps [9];
  sums_t sums;
  logic  c_valid_q;
  sums_t c_sums_q;
  rgba_t c_px_q;
  tag_t  c_tag_q;

  always_comb begin
    win_d = win_q;
    if (restart_i) begin
      for (int i = 0; i < 6; i++) begin
        win_d[i] = '0;
      end
    end else if (adv_i && b_valid_i) begin
      win_d[0] = win_q[3];
      win_d[1] = win_q[4];
      win_d[2] = win_q[5];
      win_d[3] = b_above2_i;
      win_d[4] = b_above1_i;
      win_d[5] = b_px_i;
    end
  end

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      taps[i] = win_q[i];
    end
    taps[6] = b_above2_i;
    taps[7] = b_above1_i;
    taps[8] = b_px_i;
    sums = '0;
    for (int i = 0; i < 9; i++) begin
      sums.red   = sums.red   + SumW'(taps[i].red);
      sums.green = sums.green + SumW'(taps[i].green);
      sums.blue  = sums.blue  + SumW'(taps[i].blue);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
      c_valid_q <= 1'b0;
    end else begin
      win_q <= win_d;
      if (adv_i) begin
        c_valid_q <= b_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && b_valid_i) begin
      c_sums_q <= sums;
      c_px_q   <= b_px_i;
      c_tag_q  <= b_tag_i;
    end
  end

  assign c_valid_o = c_valid_q;
  assign c_sums_o  = c_sums_q;
  assign c_px_o    = c_px_q;
  assign c_tag_o   = c_tag_q;

  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c_valid_q && c_tag_q.blur) |->
      (c_sums_q.red <= SumW'(2295) && c_sums_q.green <= SumW'(2295)
       && c_sums_q.blue <= SumW'(2295)))
    else $error("window sum above nine full-scale samples");

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    restart_i |=> (win_q[5] == '0 && win_q[2] == '0))
    else $error("window not cleared on restart");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> $stable(c_valid_q))
    else $error("sum stage moved while stalled");

endmodule

@@ hw/rtl/bbr_out.sv @@
// Output stage: divide-by-nine multiply, result register, result sequencer.
// Depends on bbr_pkg.
module bbr_out (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               c_valid_i,
  input  bbr_pkg::sums_t      c_sums_i,
  input  bbr_pkg::rgba_t      c_px_i,
  input  bbr_pkg::tag_t       c_tag_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output bbr_pkg::pix_out_t   out_data_o,
  output logic               adv_o
);
  import bbr_pkg::*;

  localparam int unsigned ProdW = SumW + $bits(DIV9_MUL);

  logic [ProdW-1:0] prod_r, prod_g, prod_b;
  rgba_t      blur_px;
  out_state_e state_q, state_d;
  rgba_t      d_blur_q, d_px_q;
  tag_t       d_tag_q;
  logic       last;
  logic       load;

  always_comb begin
    prod_r  = ProdW'(c_sums_i.red)   * ProdW'(DIV9_MUL);
    prod_g  = ProdW'(c_sums_i.green) * ProdW'(DIV9_MUL);
    prod_b  = ProdW'(c_sums_i.blue)  * ProdW'(DIV9_MUL);
    blur_px.red   = prod_r[Div9Shift +: 8];
    blur_px.green = prod_g[Div9Shift +: 8];
    blur_px.blue  = prod_b[Div9Shift +: 8];
    blur_px.alpha = ALPHA_OPAQUE;
  end

  assign last  = (state_q == ST_PASS) || (state_q == ST_BLUR && !d_tag_q.pass);
  assign adv_o = (state_q == ST_IDLE) || (!out_stall_i && last);
  assign load  = adv_o && c_valid_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: state_d = ST_IDLE;
      ST_BLUR: begin
        if (!out_stall_i) begin
          state_d = d_tag_q.pass ? ST_PASS : ST_IDLE;
        end
      end
      ST_PASS: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (load) begin
      priority if (c_tag_i.blur) begin
        state_d = ST_BLUR;
      end else if (c_tag_i.pass) begin
        state_d = ST_PASS;
      end else begin
        state_d = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      d_blur_q <= blur_px;
      d_px_q   <= c_px_i;
      d_tag_q  <= c_tag_i;
    end
  end

  assign out_valid_o = (state_q != ST_IDLE);

  always_comb begin
    unique case (state_q)
      ST_BLUR: begin
        out_data_o.red_out    = d_blur_q.red;
        out_data_o.green_out  = d_blur_q.green;
        out_data_o.blue_out   = d_blur_q.blue;
        out_data_o.alpha_out  = d_blur_q.alpha;
        out_data_o.out_col    = d_tag_q.col - CoordW'(1);
        out_data_o.out_row    = d_tag_q.row - CoordW'(1);
        out_data_o.run_last   = !d_tag_q.pass;
        out_data_o.frame_done = 1'b0;
      end
      default: begin
        out_data_o.red_out    = d_px_q.red;
        out_data_o.green_out  = d_px_q.green;
        out_data_o.blue_out   = d_px_q.blue;
        out_data_o.alpha_out  = d_px_q.alpha;
        out_data_o.out_col    = d_tag_q.col;
        out_data_o.out_row    = d_tag_q.row;
        out_data_o.run_last   = 1'b1;
        out_data_o.frame_done = d_tag_q.frame_end;
      end
    endcase
  end

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.frame_done) |-> out_data_o.run_last)
    else $error("frame end flagged on a non-final result");

  a_blur_then_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BLUR && d_tag_q.pass && !out_stall_i) |=> state_q == ST_PASS)
    else $error("border result dropped after blurred result");

  a_adv_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_o |-> (state_q == ST_IDLE || !out_stall_i))
    else $error("pipeline advanced over a stalled result");

endmodule

@@ hw/rtl/box_blur_3x3_rgb_unit.sv @@
// 3x3 box blur over a raster RGBA stream. Depends on bbr_pkg, bbr_line_mem,
// bbr_window and bbr_out. An item's first result is valid once the item has passed
// the input, window sum and result registers. Throughput: one item per cycle while
// out_stall_i is low; an item with two results holds the single output port for both,
// so the last column and row stall the input. Reset: size registers to 640 x 480,
// counters and window to zero; line stores are not cleared and need no clearing pass.
module box_blur_3x3_rgb_unit #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  bbr_pkg::pix_in_t                 in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output bbr_pkg::pix_out_t                out_data_o,
  input  logic                             cfg_we_i,
  input  logic [bbr_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [bbr_pkg::CfgDataW-1:0]     cfg_data_i
);
  import bbr_pkg::*;

  localparam int unsigned ColW  = $clog2(MAX_WIDTH);
  localparam int unsigned RowW  = $clog2(MAX_HEIGHT);
  localparam int unsigned WExtW = (ColW + 1 > CfgDataW) ? ColW + 1 : CfgDataW;
  localparam int unsigned HExtW = (RowW + 1 > CfgDataW) ? RowW + 1 : CfgDataW;

  logic [CfgDataW-1:0] cfg_width_q, cfg_height_q;
  logic                restart;
  logic [WExtW-1:0]    w_ext;
  logic [HExtW-1:0]    h_ext;
  logic [ColW-1:0]     w_last;
  logic [RowW-1:0]     h_last;
  logic [ColW-1:0]     col_q, col_d;
  logic [RowW-1:0]     row_q, row_d;
  logic                adv, accept;
  tag_t                tag_a;
  rgba_t               px_a;

  logic                b_valid_q;
  rgba_t               b_px_q;
  tag_t                b_tag_q;
  logic [ColW-1:0]     b_col_q;
  logic                fwd_q;
  rgba_t               fwd_older_q, fwd_newer_q;
  rgba_t               rd_older, rd_newer;
  rgba_t               b_above2, b_above1;
  logic                mem_we;

  logic                c_valid;
  sums_t               c_sums;
  rgba_t               c_px;
  tag_t                c_tag;

  assign restart = cfg_we_i && (cfg_idx_i == CFG_IMAGE_WIDTH || cfg_idx_i == CFG_IMAGE_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= IMAGE_WIDTH_RESET;
      cfg_height_q <= IMAGE_HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  cfg_width_q  <= cfg_data_i;
        CFG_IMAGE_HEIGHT: cfg_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_ext = WExtW'(cfg_width_q);
    h_ext = HExtW'(cfg_height_q);
    priority if (w_ext == '0) begin
      w_last = '0;
    end else if (w_ext > WExtW'(MAX_WIDTH)) begin
      w_last = ColW'(MAX_WIDTH - 1);
    end else begin
      w_last = ColW'(w_ext - WExtW'(1));
    end
    priority if (h_ext == '0) begin
      h_last = '0;
    end else if (h_ext > HExtW'(MAX_HEIGHT)) begin
      h_last = RowW'(MAX_HEIGHT - 1);
    end else begin
      h_last = RowW'(h_ext - HExtW'(1));
    end
  end

  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (restart) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (col_q == w_last) begin
        col_d = '0;
        row_d = (row_q == h_last) ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_comb begin
    px_a.red        = in_data_i.red_in;
    px_a.green      = in_data_i.green_in;
    px_a.blue       = in_data_i.blue_in;
    px_a.alpha      = in_data_i.alpha_in;
    tag_a.blur      = (col_q >= ColW'(2)) && (row_q >= RowW'(2));
    tag_a.pass      = (row_q == '0) || (col_q == '0) || (col_q == w_last) || (row_q == h_last);
    tag_a.frame_end = (col_q == w_last) && (row_q == h_last);
    tag_a.col       = CoordW'(col_q);
    tag_a.row       = CoordW'(row_q);
  end

  assign mem_we = adv && b_valid_q;

  bbr_line_mem #(
    .Depth (MAX_WIDTH),
    .Width ($bits(rgba_t))
  ) u_older (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (b_col_q),
    .wdata_i (b_above1),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (rd_older)
  );

  bbr_line_mem #(
    .Depth (MAX_WIDTH),
    .Width ($bits(rgba_t))
  ) u_newer (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (b_col_q),
    .wdata_i (b_px_q),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (rd_newer)
  );

  assign b_above2 = fwd_q ? fwd_older_q : rd_older;
  assign b_above1 = fwd_q ? fwd_newer_q : rd_newer;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      fwd_q     <= 1'b0;
    end else begin
      if (adv) begin
        b_valid_q <= accept;
      end
      if (accept) begin
        fwd_q <= b_valid_q && (b_col_q == col_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_px_q      <= px_a;
      b_tag_q     <= tag_a;
      b_col_q     <= col_q;
      fwd_older_q <= b_above1;
      fwd_newer_q <= b_px_q;
    end
  end

  bbr_window u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .restart_i  (restart),
    .adv_i      (adv),
    .b_valid_i  (b_valid_q),
    .b_px_i     (b_px_q),
    .b_above2_i (b_above2),
    .b_above1_i (b_above1),
    .b_tag_i    (b_tag_q),
    .c_valid_o  (c_valid),
    .c_sums_o   (c_sums),
    .c_px_o     (c_px),
    .c_tag_o    (c_tag)
  );

  bbr_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .c_valid_i   (c_valid),
    .c_sums_i    (c_sums),
    .c_px_i      (c_px),
    .c_tag_i     (c_tag),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .adv_o       (adv)
  );

  a_stall_needs_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  a_col_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= w_last)
    else $error("column counter beyond frame width");

  a_row_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= h_last)
    else $error("row counter beyond frame height");

  a_fwd_single_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && b_valid_q && b_col_q == col_q) |-> w_last == '0)
    else $error("line store read and write collide on a wide frame");

endmodule
